// ----- hw/rtl/mss_pkg.sv -----
// Package for the multi-stepper phase sequencer: beat structs, state codes,
// command codes, reset values and a small helper function.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package mss_pkg;

   localparam int NUM_MOTORS_DEF = 4;
   localparam int DELAY_BITS_DEF = 16;

   localparam logic [15:0] FULL_PAT_RESET = 16'd40035;
   localparam logic [31:0] HALF_PAT_RESET = 32'd2563007025;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FULL_PATTERNS = 1'b0,
      CSR_HALF_PATTERNS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ACT_TICK       = 3'd0,
      ACT_ATTACH     = 3'd1,
      ACT_DETACH     = 3'd2,
      ACT_MOVE       = 3'd3,
      ACT_ROTATE     = 3'd4,
      ACT_SET_DELAY  = 3'd5,
      ACT_SET_ODO    = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      MODE_STOP     = 3'd0,
      MODE_BRAKE    = 3'd1,
      MODE_FORWARD  = 3'd2,
      MODE_BACKWARD = 3'd3,
      MODE_REVERSE  = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      RS_DETACHED = 3'd0,
      RS_STOPPED  = 3'd1,
      RS_STOP     = 3'd2,
      RS_BRAKE    = 3'd3,
      RS_BRAKED   = 3'd4,
      RS_FORWARD  = 3'd5,
      RS_BACKWARD = 3'd6,
      RS_REVERSE  = 3'd7
   } run_state_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_BACK = 2'd3
   } dir_type;

   typedef struct packed {
      logic [2:0]         action;
      logic [1:0]         motor;
      logic [2:0]         mode;
      logic signed [31:0] value;
      logic               half_step;
   } req_type;

   typedef struct packed {
      logic [15:0]        coil_pins;
      logic [2:0]         motor_status;
      logic               moving;
      logic signed [31:0] odometer;
      logic [31:0]        steps_done;
      logic               accepted;
   } rsp_type;

   // Per-motor record, apart from the tick counter and delay whose width
   // follows the delay parameter.
   typedef struct packed {
      run_state_type run_state;
      logic [2:0]    phase;
      dir_type       direction;
      logic [31:0]   step_limit;
      logic [31:0]   step_count;
      logic [31:0]   position;
      logic          half_mode;
      logic [3:0]    coil;
   } motor_rec_type;

   localparam motor_rec_type REC_RESET = '{
      run_state:  RS_DETACHED,
      phase:      3'd0,
      direction:  DIR_NONE,
      step_limit: 32'd0,
      step_count: 32'd0,
      position:   32'd0,
      half_mode:  1'b0,
      coil:       4'd0
   };

   // A motor is counting ticks unless it is detached, stopped or braked.
   function automatic logic is_moving(input run_state_type st);
      return (st != RS_DETACHED) && (st != RS_STOPPED) && (st != RS_BRAKED);
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mss_step_unit.sv -----
// Shared update unit: applies one tick or one command to one motor record.
// Purely combinational; depends on mss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mss_step_unit #(
   parameter int DELAY_BITS = mss_pkg::DELAY_BITS_DEF
) (
   input  mss_pkg::motor_rec_type rec_i,
   input  logic [DELAY_BITS-1:0]  tick_i,
   input  logic [DELAY_BITS-1:0]  delay_i,
   input  mss_pkg::req_type       req_i,
   input  logic [15:0]            full_pat_i,
   input  logic [31:0]            half_pat_i,
   output mss_pkg::motor_rec_type rec_o,
   output logic [DELAY_BITS-1:0]  tick_o,
   output logic [DELAY_BITS-1:0]  delay_o,
   output logic                   ok_o
);
   import mss_pkg::*;

   logic [2:0]            last_phase;
   logic [2:0]            nxt_phase;
   logic [31:0]           nxt_position;
   logic [3:0]            nxt_coil;
   logic                  can_step;
   logic [DELAY_BITS-1:0] clamped;
   logic [31:0]           abs_value;
   run_state_type         mode_state;
   logic                  mode_ok;

   function automatic dir_type motion_dir(input run_state_type st, input dir_type d);
      dir_type r;
      r = DIR_NONE;
      case (st)
         RS_FORWARD:  r = DIR_FWD;
         RS_BACKWARD: r = DIR_BACK;
         RS_REVERSE: begin
            case (d)
               DIR_FWD:  r = DIR_BACK;
               DIR_BACK: r = DIR_FWD;
               default:  r = DIR_NONE;
            endcase
         end
         default:     r = DIR_NONE;
      endcase
      return r;
   endfunction

   // Next phase, position and coil pattern of one step.
   always_comb begin
      last_phase   = rec_i.half_mode ? 3'd7 : 3'd3;
      nxt_phase    = rec_i.phase;
      nxt_position = rec_i.position;
      case (rec_i.direction)
         DIR_FWD: begin
            nxt_phase    = (rec_i.phase >= last_phase) ? 3'd0 : rec_i.phase + 3'd1;
            nxt_position = rec_i.position + 32'd1;
         end
         DIR_BACK: begin
            nxt_phase    = (rec_i.phase == 3'd0) ? last_phase : rec_i.phase - 3'd1;
            nxt_position = rec_i.position - 32'd1;
         end
         default: begin
            nxt_phase = (rec_i.phase > last_phase) ? 3'd0 : rec_i.phase;
         end
      endcase
      if (rec_i.half_mode) begin
         nxt_coil = half_pat_i[{nxt_phase, 2'b00} +: 4];
      end else begin
         nxt_coil = full_pat_i[{nxt_phase[1:0], 2'b00} +: 4];
      end
      can_step = (rec_i.step_limit == 32'd0) || (rec_i.step_count < rec_i.step_limit);
   end

   // Operand shaping for the commands.
   always_comb begin
      if (req_i.value <= 32'sd0) begin
         clamped = '0;
      end else if (($unsigned(req_i.value) >> DELAY_BITS) != 32'd0) begin
         clamped = '1;
      end else begin
         clamped = req_i.value[DELAY_BITS-1:0];
      end
      abs_value = req_i.value[31] ? (32'd0 - $unsigned(req_i.value)) : $unsigned(req_i.value);
      mode_ok    = 1'b1;
      mode_state = RS_STOP;
      case (mode_type'(req_i.mode))
         MODE_STOP:     mode_state = RS_STOP;
         MODE_BRAKE:    mode_state = RS_BRAKE;
         MODE_FORWARD:  mode_state = RS_FORWARD;
         MODE_BACKWARD: mode_state = RS_BACKWARD;
         MODE_REVERSE:  mode_state = RS_REVERSE;
         default:       mode_ok = 1'b0;
      endcase
   end

   always_comb begin
      rec_o   = rec_i;
      tick_o  = tick_i;
      delay_o = delay_i;
      ok_o    = 1'b1;
      case (action_type'(req_i.action))
         ACT_TICK: begin
            if (is_moving(rec_i.run_state)) begin
               if (tick_i < delay_i) begin
                  tick_o = tick_i + 1'b1;
               end else begin
                  tick_o = DELAY_BITS'(1);
                  case (rec_i.run_state)
                     RS_BRAKE: rec_o.run_state = RS_BRAKED;
                     RS_STOP: begin
                        rec_o.run_state = RS_STOPPED;
                        rec_o.coil      = 4'd0;
                     end
                     default: begin
                        if (can_step) begin
                           rec_o.phase    = nxt_phase;
                           rec_o.position = nxt_position;
                           rec_o.coil     = nxt_coil;
                           if (rec_i.step_limit != 32'd0) begin
                              rec_o.step_count = rec_i.step_count + 32'd1;
                           end
                        end else begin
                           rec_o.run_state = RS_BRAKE;
                        end
                     end
                  endcase
               end
            end
         end
         ACT_ATTACH: begin
            rec_o           = REC_RESET;
            rec_o.run_state = RS_STOPPED;
            rec_o.half_mode = req_i.half_step;
            tick_o          = '0;
            delay_o         = clamped;
         end
         ACT_DETACH: begin
            if (rec_i.run_state == RS_DETACHED) begin
               ok_o = 1'b0;
            end else begin
               rec_o.run_state = RS_DETACHED;
               rec_o.coil      = 4'd0;
            end
         end
         ACT_MOVE: begin
            if ((rec_i.run_state == RS_DETACHED) || !mode_ok) begin
               ok_o = 1'b0;
            end else begin
               rec_o.step_limit = 32'd0;
               rec_o.run_state  = mode_state;
               rec_o.direction  = motion_dir(mode_state, rec_i.direction);
            end
         end
         ACT_ROTATE: begin
            if (rec_i.run_state == RS_DETACHED) begin
               ok_o = 1'b0;
            end else if (req_i.value == 32'sd0) begin
               rec_o.run_state = RS_BRAKE;
               rec_o.direction = DIR_NONE;
            end else begin
               rec_o.step_limit = abs_value;
               rec_o.step_count = 32'd0;
               rec_o.run_state  = req_i.value[31] ? RS_BACKWARD : RS_FORWARD;
               rec_o.direction  = req_i.value[31] ? DIR_BACK : DIR_FWD;
            end
         end
         ACT_SET_DELAY: begin
            if ((req_i.value == 32'sd0) || req_i.value[31]) begin
               ok_o = 1'b0;
            end else begin
               delay_o = clamped;
            end
         end
         ACT_SET_ODO: begin
            rec_o.position = $unsigned(req_i.value);
         end
         default: begin
            ok_o = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/multi_stepper_phase_sequencer_top.sv -----
// Top level of the multi-stepper phase sequencer: command sequencer, motor
// record registers and pattern registers around the shared update unit.
// Depends on mss_pkg and mss_step_unit.
//
//   Port group   Direction  Handshake                 Beat
//   req_*        in         start high, busy low      mss_pkg::req_type
//   rsp_*        out        rsp_strobe, one cycle     mss_pkg::rsp_type
//   csr_*        in         csr_we, no wait           32-bit register data
//
// A tick beat walks the shared unit over every motor, one motor per cycle,
// then passes the response state before busy drops; a command beat touches
// only its own motor in the execute state, or skips that state when the
// motor does not exist. The response beat is strobed in the first cycle
// with busy low, and a new beat may be taken in that very cycle. Reset is
// synchronous and returns every motor to detached with coils off and the
// pattern registers to their defaults. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module multi_stepper_phase_sequencer_top #(
   parameter int NUM_MOTORS = mss_pkg::NUM_MOTORS_DEF,
   parameter int DELAY_BITS = mss_pkg::DELAY_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  mss_pkg::req_type                   req_data,
   output logic                               rsp_strobe,
   output mss_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [mss_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mss_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mss_pkg::*;

   localparam int IDX_W      = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
   localparam int PIN_MOTORS = (NUM_MOTORS < 4) ? NUM_MOTORS : 4;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_MOTORS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } seq_state_type;

   seq_state_type         state_ff;
   req_type               req_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic                  valid_ff;
   logic                  ok_ff;
   logic                  strobe_ff;
   rsp_type               rsp_ff;

   logic [15:0]           full_pat_ff;
   logic [31:0]           half_pat_ff;

   motor_rec_type         rec_ff   [NUM_MOTORS];
   logic [DELAY_BITS-1:0] tick_ff  [NUM_MOTORS];
   logic [DELAY_BITS-1:0] delay_ff [NUM_MOTORS];

   motor_rec_type         rec_in;
   logic [DELAY_BITS-1:0] tick_in;
   logic [DELAY_BITS-1:0] delay_in;
   logic                  unit_ok;
   logic                  motor_ok;
   logic                  is_tick;
   logic [15:0]           pins;
   motor_rec_type         cur_rec;

   assign motor_ok = (32'(req_data.motor) < 32'(NUM_MOTORS));
   assign is_tick  = (action_type'(req_ff.action) == ACT_TICK);
   assign cur_rec  = rec_ff[idx_ff];

   // The one arithmetic unit, pointed at the motor under the index register.
   mss_step_unit #(
      .DELAY_BITS (DELAY_BITS)
   ) u_step (
      .rec_i      (cur_rec),
      .tick_i     (tick_ff[idx_ff]),
      .delay_i    (delay_ff[idx_ff]),
      .req_i      (req_ff),
      .full_pat_i (full_pat_ff),
      .half_pat_i (half_pat_ff),
      .rec_o      (rec_in),
      .tick_o     (tick_in),
      .delay_o    (delay_in),
      .ok_o       (unit_ok)
   );

   // Coil drive of the first four motors, read from fixed places.
   always_comb begin
      pins = 16'd0;
      for (int i = 0; i < PIN_MOTORS; i++) begin
         pins[4*i +: 4] = rec_ff[IDX_W'(i)].coil;
      end
   end

   // Pattern registers, written straight from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         full_pat_ff <= FULL_PAT_RESET;
         half_pat_ff <= HALF_PAT_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FULL_PATTERNS: full_pat_ff <= csr_wdata[15:0];
            CSR_HALF_PATTERNS: half_pat_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // Motor records: written back from the unit in each execute cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_MOTORS; i++) begin
            rec_ff[IDX_W'(i)]   <= REC_RESET;
            tick_ff[IDX_W'(i)]  <= '0;
            delay_ff[IDX_W'(i)] <= '0;
         end
      end else if (state_ff == ST_EXEC) begin
         rec_ff[idx_ff]   <= rec_in;
         tick_ff[idx_ff]  <= tick_in;
         delay_ff[idx_ff] <= delay_in;
      end
   end

   // Sequencer. A tick sweeps the index over all motors; a command stays on
   // its own motor. A command to a motor that does not exist skips the
   // execute cycle and is refused.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         idx_ff    <= '0;
         valid_ff  <= 1'b0;
         ok_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               strobe_ff <= 1'b0;
               if (start) begin
                  req_ff   <= req_data;
                  valid_ff <= motor_ok;
                  if (action_type'(req_data.action) == ACT_TICK) begin
                     idx_ff   <= '0;
                     state_ff <= ST_EXEC;
                  end else if (!motor_ok) begin
                     idx_ff   <= '0;
                     ok_ff    <= 1'b0;
                     state_ff <= ST_RESP;
                  end else begin
                     idx_ff   <= IDX_W'(req_data.motor);
                     state_ff <= ST_EXEC;
                  end
               end
            end
            ST_EXEC: begin
               strobe_ff <= 1'b0;
               ok_ff     <= unit_ok;
               if (is_tick && (idx_ff != LAST_IDX)) begin
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  idx_ff   <= valid_ff ? IDX_W'(req_ff.motor) : '0;
                  state_ff <= ST_RESP;
               end
            end
            ST_RESP: begin
               rsp_ff.coil_pins <= pins;
               rsp_ff.accepted  <= ok_ff;
               if (valid_ff) begin
                  rsp_ff.motor_status <= cur_rec.run_state;
                  rsp_ff.moving       <= is_moving(cur_rec.run_state);
                  rsp_ff.odometer     <= $signed(cur_rec.position);
                  rsp_ff.steps_done   <= cur_rec.step_count;
               end else begin
                  rsp_ff.motor_status <= 3'd0;
                  rsp_ff.moving       <= 1'b0;
                  rsp_ff.odometer     <= 32'sd0;
                  rsp_ff.steps_done   <= 32'd0;
               end
               strobe_ff <= 1'b1;
               state_ff  <= ST_IDLE;
            end
            default: begin
               strobe_ff <= 1'b0;
               state_ff  <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/mss_checker.sv -----
// Port-level checker for the multi-stepper phase sequencer, bound to the
// top level. Depends on mss_pkg and multi_stepper_phase_sequencer_top.
`timescale 1ns / 1ps
`default_nettype none

module mss_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input mss_pkg::rsp_type rsp_data
);
   import mss_pkg::*;

   // Every accepted beat makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("beat accepted without the block going busy");

   // A response is only strobed right at the end of a busy spell.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("response strobed outside the end of a busy spell");

   // Every busy spell ends in a response strobe.
   a_busy_ends_in_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy spell ended without a response");

   // A motor that is detached, stopped or braked is never reported moving.
   a_moving_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ((rsp_data.motor_status == RS_DETACHED)
                   || (rsp_data.motor_status == RS_STOPPED)
                   || (rsp_data.motor_status == RS_BRAKED))) |-> !rsp_data.moving)
      else $error("moving flag set on a resting motor");

endmodule

bind multi_stepper_phase_sequencer_top mss_checker u_mss_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire

// ----- test/tb_multi_stepper_phase_sequencer_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the multi-stepper phase sequencer. A model of the
// motor records predicts every status beat, and each beat is checked against it.
// Depends on mss_pkg and multi_stepper_phase_sequencer_top.

module tb_multi_stepper_phase_sequencer_top;
   import mss_pkg::*;

   localparam int MOTORS = NUM_MOTORS_DEF;
   localparam logic [15:0] DELAY_CAP = 16'hFFFF;
   // Codes that the block has to refuse: the spare action and the move kinds
   // past reverse.
   localparam logic [2:0] ACT_UNUSED = 3'd7;
   localparam logic [2:0] MODE_BAD_LO = 3'd5;
   localparam logic [2:0] MODE_BAD_HI = 3'd7;
   localparam logic [2:0] MODE_ANY = 3'd0;
   // A tick beat keeps the block busy while it walks every motor, and the status
   // beat is strobed as busy drops; the settle wait is sized to cover that tail.
   localparam int SETTLE_CYCLES = MOTORS + 6;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Our own copy of the pattern registers and of every motor record.
   logic [15:0] full_table;
   logic [31:0] half_table;
   run_state_type mot_state [MOTORS];
   logic [2:0] mot_phase [MOTORS];
   dir_type mot_dir [MOTORS];
   logic [15:0] mot_ticks [MOTORS];
   logic [15:0] mot_delay [MOTORS];
   logic [31:0] mot_limit [MOTORS];
   logic [31:0] mot_count [MOTORS];
   logic [31:0] mot_pos [MOTORS];
   logic mot_half [MOTORS];
   logic [3:0] mot_coil [MOTORS];

   // Status beats that the block still owes us, oldest first.
   rsp_type status_due [$];

   int fail_count = 0;
   int reported = 0;
   int idle_cycles = 0;
   int burst_left = 0;

   multi_stepper_phase_sequencer_top dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Motor model
   // ---------------------------------------------------------------------

   // A delay of zero or less means a step on every tick; anything that does
   // not fit the delay counter is held at its largest value.
   function automatic logic [15:0] clamp_ticks(input logic signed [31:0] raw);
      if (raw <= 0) return 16'd0;
      if (raw > 32'sd65535) return DELAY_CAP;
      return raw[15:0];
   endfunction

   // Puts a motor into a new run state. Reverse flips the direction, so a
   // motor without a direction stays where it is.
   function automatic void set_motion(input int m, input run_state_type st);
      mot_state[m] = st;
      case (st)
         RS_FORWARD: mot_dir[m] = DIR_FWD;
         RS_BACKWARD: mot_dir[m] = DIR_BACK;
         RS_REVERSE: mot_dir[m] = dir_type'(2'd0 - mot_dir[m]);
         default: mot_dir[m] = DIR_NONE;
      endcase
   endfunction

   // Applies one command beat to the model and works out the status beat
   // that the block must return for it.
   function automatic rsp_type step_motors(input req_type item);
      rsp_type beat;
      logic ok;
      int m;
      int span;
      int nxt;
      ok = 1'b1;
      m = int'(item.motor);
      case (item.action)
         ACT_TICK: begin
            for (int i = 0; i < MOTORS; i++) begin
               if (mot_state[i] == RS_DETACHED || mot_state[i] == RS_STOPPED ||
                   mot_state[i] == RS_BRAKED)
                  continue;
               if (mot_ticks[i] < mot_delay[i]) begin
                  mot_ticks[i] = mot_ticks[i] + 16'd1;
                  continue;
               end
               mot_ticks[i] = 16'd1;
               if (mot_state[i] == RS_BRAKE) begin
                  mot_state[i] = RS_BRAKED;
               end else if (mot_state[i] == RS_STOP) begin
                  mot_coil[i] = 4'd0;
                  mot_state[i] = RS_STOPPED;
               end else if (mot_limit[i] == 32'd0 || mot_count[i] < mot_limit[i]) begin
                  // One step: move the phase round the table and the odometer.
                  span = mot_half[i] ? 8 : 4;
                  nxt = int'(mot_phase[i]);
                  if (mot_dir[i] == DIR_FWD) begin
                     nxt++;
                     mot_pos[i] = mot_pos[i] + 32'd1;
                  end else if (mot_dir[i] == DIR_BACK) begin
                     nxt--;
                     mot_pos[i] = mot_pos[i] - 32'd1;
                  end
                  if (nxt >= span) nxt = 0;
                  if (nxt < 0) nxt = span - 1;
                  mot_phase[i] = 3'(nxt);
                  mot_coil[i] = mot_half[i] ? half_table[4*nxt +: 4] : full_table[4*nxt +: 4];
                  if (mot_limit[i] != 32'd0) mot_count[i] = mot_count[i] + 32'd1;
               end else begin
                  mot_state[i] = RS_BRAKE;
               end
            end
         end
         ACT_ATTACH: begin
            mot_half[m] = item.half_step;
            mot_state[m] = RS_STOPPED;
            mot_phase[m] = 3'd0;
            mot_dir[m] = DIR_NONE;
            mot_count[m] = 32'd0;
            mot_ticks[m] = 16'd0;
            mot_delay[m] = clamp_ticks(item.value);
            mot_limit[m] = 32'd0;
            mot_pos[m] = 32'd0;
            mot_coil[m] = 4'd0;
         end
         ACT_DETACH: begin
            if (mot_state[m] == RS_DETACHED) begin
               ok = 1'b0;
            end else begin
               mot_state[m] = RS_DETACHED;
               mot_coil[m] = 4'd0;
            end
         end
         ACT_MOVE: begin
            if (mot_state[m] == RS_DETACHED || item.mode > MODE_REVERSE) begin
               ok = 1'b0;
            end else begin
               mot_limit[m] = 32'd0;
               case (item.mode)
                  MODE_STOP: set_motion(m, RS_STOP);
                  MODE_BRAKE: set_motion(m, RS_BRAKE);
                  MODE_FORWARD: set_motion(m, RS_FORWARD);
                  MODE_BACKWARD: set_motion(m, RS_BACKWARD);
                  default: set_motion(m, RS_REVERSE);
               endcase
            end
         end
         ACT_ROTATE: begin
            if (mot_state[m] == RS_DETACHED) begin
               ok = 1'b0;
            end else if (item.value == 32'd0) begin
               // A rotation by nothing brakes and leaves the limit alone.
               set_motion(m, RS_BRAKE);
            end else begin
               mot_limit[m] = item.value[31] ? 32'd0 - item.value : item.value;
               mot_count[m] = 32'd0;
               set_motion(m, item.value[31] ? RS_BACKWARD : RS_FORWARD);
            end
         end
         ACT_SET_DELAY: begin
            if (item.value == 32'd0 || item.value[31]) ok = 1'b0;
            else mot_delay[m] = clamp_ticks(item.value);
         end
         ACT_SET_ODO: begin
            mot_pos[m] = item.value;
         end
         default: begin
            ok = 1'b0;
         end
      endcase

      beat = '0;
      for (int i = 0; i < MOTORS; i++) beat.coil_pins[4*i +: 4] = mot_coil[i];
      beat.motor_status = mot_state[m];
      beat.moving = (mot_state[m] != RS_DETACHED) && (mot_state[m] != RS_STOPPED) &&
                    (mot_state[m] != RS_BRAKED);
      beat.odometer = mot_pos[m];
      beat.steps_done = mot_count[m];
      beat.accepted = ok;
      return beat;
   endfunction

   // ---------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------

   function automatic req_type cmd(input logic [2:0] action, input logic [1:0] motor,
                                   input logic [2:0] mode, input logic [31:0] value,
                                   input logic half);
      req_type item;
      item.action = action;
      item.motor = motor;
      item.mode = mode;
      item.value = value;
      item.half_step = half;
      return item;
   endfunction

   // Offers one beat from a falling edge and holds it until a rising edge
   // finds the block free. Start is left high, so that back-to-back beats
   // keep it high; whoever pauses lowers it.
   task automatic send_item(input req_type item);
      start = 1'b1;
      req_data = item;
      do @(posedge clock); while (busy !== 1'b0);
      status_due.push_back(step_motors(item));
      @(negedge clock);
   endtask

   // The sender works in bursts. Roughly a third of the bursts follow on
   // without a gap, which gives long stretches of back-to-back beats; the
   // rest wait a few cycles first, so that gaps land on every cycle of a
   // tick walk.
   task automatic send_paced(input req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      send_item(item);
   endtask

   // Waits until every status beat has come back and the block has had time
   // to finish any tick walk, so that the pattern registers may be written.
   task automatic drain_and_settle();
      start = 1'b0;
      while (status_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_patterns(input logic [15:0] full_pat, input logic [31:0] half_pat);
      drain_and_settle();
      csr_we = 1'b1;
      csr_index = CSR_FULL_PATTERNS;
      csr_wdata = {16'd0, full_pat};
      full_table = full_pat;
      @(negedge clock);
      csr_index = CSR_HALF_PATTERNS;
      csr_wdata = half_pat;
      half_table = half_pat;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Random traffic. Ticks dominate so that motors really turn; delays and
   // step counts are mostly small so that limits, stops and brakes settle
   // often. A small share is noise: refused codes, huge or negative values.
   task automatic run_random(input int count);
      req_type item;
      int pick;
      for (int n = 0; n < count; n++) begin
         item.action = ACT_TICK;
         item.motor = 2'($urandom_range(0, 3));
         item.mode = 3'($urandom_range(0, 7));
         item.value = $urandom;
         item.half_step = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 99);
         if (pick < 52) begin
            item.action = ACT_TICK;
         end else if (pick < 60) begin
            item.action = ACT_ATTACH;
            if ($urandom_range(0, 5) != 0) item.value = 32'($urandom_range(0, 3));
         end else if (pick < 64) begin
            item.action = ACT_DETACH;
         end else if (pick < 76) begin
            item.action = ACT_MOVE;
            if ($urandom_range(0, 9) != 0) item.mode = 3'($urandom_range(0, 4));
         end else if (pick < 86) begin
            item.action = ACT_ROTATE;
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               item.value = 32'd0;
            end else if (pick != 1) begin
               item.value = 32'($urandom_range(1, 12));
               if ($urandom_range(0, 1) != 0) item.value = -item.value;
            end
         end else if (pick < 93) begin
            item.action = ACT_SET_DELAY;
            pick = $urandom_range(0, 9);
            if (pick == 0) item.value = 32'd0;
            else if (pick == 1) item.value[31] = 1'b1;
            else if (pick != 2) item.value = 32'($urandom_range(1, 3));
         end else if (pick < 99) begin
            item.action = ACT_SET_ODO;
         end else begin
            item.action = ACT_UNUSED;
         end
         send_paced(item);
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Refusals on a detached motor, delay clamping and saturation, full and
   // half step, a limited rotation running into brake, reverse with and
   // without a direction, stop and brake settling, odometer extremes and the
   // spare action code.
   task automatic test_command_corners();
      send_paced(cmd(ACT_DETACH, 2'd3, MODE_ANY, 32'd0, 1'b0));
      send_paced(cmd(ACT_MOVE, 2'd3, MODE_FORWARD, 32'd0, 1'b0));
      send_paced(cmd(ACT_ROTATE, 2'd3, MODE_ANY, 32'd5, 1'b0));
      send_paced(cmd(ACT_ATTACH, 2'd0, MODE_ANY, -32'sd7, 1'b0));
      send_paced(cmd(ACT_ATTACH, 2'd1, MODE_ANY, 32'd1, 1'b1));
      send_paced(cmd(ACT_ATTACH, 2'd2, MODE_ANY, 32'h7FFF_FFFF, 1'b0));
      send_paced(cmd(ACT_SET_DELAY, 2'd2, MODE_ANY, 32'd0, 1'b0));
      send_paced(cmd(ACT_SET_DELAY, 2'd2, MODE_ANY, 32'h8000_0000, 1'b0));
      send_paced(cmd(ACT_SET_DELAY, 2'd2, MODE_ANY, 32'd70000, 1'b0));
      send_paced(cmd(ACT_SET_DELAY, 2'd2, MODE_ANY, 32'd1, 1'b0));
      send_paced(cmd(ACT_MOVE, 2'd0, MODE_FORWARD, 32'd0, 1'b0));
      send_paced(cmd(ACT_ROTATE, 2'd1, MODE_ANY, -32'sd2, 1'b1));
      send_paced(cmd(ACT_MOVE, 2'd2, MODE_REVERSE, 32'd0, 1'b0));
      repeat (3) send_paced(cmd(ACT_TICK, 2'd1, MODE_ANY, 32'hFFFF_FFFF, 1'b1));
      send_paced(cmd(ACT_MOVE, 2'd0, MODE_REVERSE, 32'd0, 1'b0));
      send_paced(cmd(ACT_MOVE, 2'd0, MODE_BAD_HI, 32'd0, 1'b0));
      send_paced(cmd(ACT_MOVE, 2'd0, MODE_BAD_LO, 32'd0, 1'b0));
      repeat (3) send_paced(cmd(ACT_TICK, 2'd1, MODE_ANY, 32'd0, 1'b0));
      send_paced(cmd(ACT_ROTATE, 2'd0, MODE_ANY, 32'd0, 1'b0));
      send_paced(cmd(ACT_MOVE, 2'd2, MODE_STOP, 32'd0, 1'b0));
      send_paced(cmd(ACT_SET_ODO, 2'd0, MODE_ANY, 32'h8000_0000, 1'b0));
      send_paced(cmd(ACT_SET_ODO, 2'd1, MODE_ANY, 32'h7FFF_FFFF, 1'b0));
      repeat (2) send_paced(cmd(ACT_TICK, 2'd2, MODE_ANY, 32'd0, 1'b0));
      send_paced(cmd(ACT_UNUSED, 2'd3, MODE_BAD_HI, 32'hFFFF_FFFF, 1'b1));
      send_paced(cmd(ACT_DETACH, 2'd0, MODE_ANY, 32'd0, 1'b0));
      send_paced(cmd(ACT_ATTACH, 2'd3, MODE_ANY, 32'h8000_0000, 1'b1));
      send_paced(cmd(ACT_ROTATE, 2'd3, MODE_ANY, 32'h8000_0000, 1'b0));
      send_paced(cmd(ACT_TICK, 2'd3, MODE_ANY, 32'd0, 1'b0));
   endtask

   // All-zero and all-one coil tables, each way round.
   task automatic test_pattern_extremes();
      write_patterns(16'hFFFF, 32'h0000_0000);
      run_random(350);
      write_patterns(16'h0000, 32'hFFFF_FFFF);
      run_random(350);
   endtask

   task automatic test_random_patterns();
      write_patterns(16'($urandom_range(0, 65535)), $urandom);
      run_random(400);
   endtask

   // Back to the tables that reset gives, written explicitly this time.
   task automatic test_default_patterns();
      write_patterns(FULL_PAT_RESET, HALF_PAT_RESET);
      run_random(350);
   endtask

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   // Every strobed status beat is compared, field by field, with the oldest
   // prediction. The receiver cannot hold beats off, so each strobe is taken.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (status_due.size() == 0) begin
            fail_count++;
            if (reported < MAX_REPORTS) begin
               reported++;
               $display("%0t: status beat with none outstanding: %p", $realtime, rsp_data);
            end
         end else begin
            want = status_due.pop_front();
            if (rsp_data.coil_pins !== want.coil_pins ||
                rsp_data.motor_status !== want.motor_status ||
                rsp_data.moving !== want.moving ||
                rsp_data.odometer !== want.odometer ||
                rsp_data.steps_done !== want.steps_done ||
                rsp_data.accepted !== want.accepted) begin
               fail_count++;
               if (reported < MAX_REPORTS) begin
                  reported++;
                  $display("%0t: status beat mismatch", $realtime);
                  $display("   want pins=%h state=%0d moving=%b odo=%0d done=%0d acc=%b",
                           want.coil_pins, want.motor_status, want.moving, want.odometer,
                           want.steps_done, want.accepted);
                  $display("   got  pins=%h state=%0d moving=%b odo=%0d done=%0d acc=%b",
                           rsp_data.coil_pins, rsp_data.motor_status, rsp_data.moving,
                           rsp_data.odometer, rsp_data.steps_done, rsp_data.accepted);
               end
            end
         end
      end
   end

   // The watchdog counts cycles in which no beat moves on either side and
   // no register is written; a hung block ends the run here.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      full_table = FULL_PAT_RESET;
      half_table = HALF_PAT_RESET;
      for (int i = 0; i < MOTORS; i++) begin
         mot_state[i] = RS_DETACHED;
         mot_phase[i] = 3'd0;
         mot_dir[i] = DIR_NONE;
         mot_ticks[i] = 16'd0;
         mot_delay[i] = 16'd0;
         mot_limit[i] = 32'd0;
         mot_count[i] = 32'd0;
         mot_pos[i] = 32'd0;
         mot_half[i] = 1'b0;
         mot_coil[i] = 4'd0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_command_corners();
      test_pattern_extremes();
      test_random_patterns();
      test_default_patterns();

      drain_and_settle();
      if (fail_count == 0 && status_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
